>>> sv/iirdf_pkg.sv
// Shared constants for the direct-form-I IIR filter.
package iirdf_pkg;

    localparam int FILTER_ORDER_DEF = 3;
    localparam int SAMPLE_BITS_DEF  = 16;

    localparam int MAX_TAPS   = 3;
    localparam int COEF_W     = 24;
    localparam int HIST_EXTRA = 16;
    localparam int HIST_SHIFT = 20;
    localparam int ACC_W      = 64;
    localparam int CFG_IDX_W  = 3;

    // register indexes: b0..b3 at REG_FF0.., a1..a3 at REG_FB1..
    localparam logic [CFG_IDX_W-1:0] REG_FF0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FB1 = 3'd4;

endpackage

>>> sv/iirdf_coef_regs.sv
// Coefficient register bank written through the configuration port.
module iirdf_coef_regs #(
    parameter int TAPS = 3
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [iirdf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [iirdf_pkg::COEF_W-1:0]          cfg_wdata,
    output logic signed [iirdf_pkg::COEF_W-1:0]   ff_coef [TAPS+1],
    output logic signed [iirdf_pkg::COEF_W-1:0]   fb_coef [TAPS]
);
    import iirdf_pkg::*;

    logic signed [COEF_W-1:0] ff_reg [TAPS+1];
    logic signed [COEF_W-1:0] fb_reg [TAPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= TAPS; k++) begin
                ff_reg[k] <= '0;
            end
            for (int k = 0; k < TAPS; k++) begin
                fb_reg[k] <= '0;
            end
        end else if (cfg_we) begin
            for (int k = 0; k <= TAPS; k++) begin
                if (cfg_index == REG_FF0 + CFG_IDX_W'(k)) begin
                    ff_reg[k] <= cfg_wdata;
                end
            end
            for (int k = 0; k < TAPS; k++) begin
                if (cfg_index == REG_FB1 + CFG_IDX_W'(k)) begin
                    fb_reg[k] <= cfg_wdata;
                end
            end
        end
    end

    assign ff_coef = ff_reg;
    assign fb_coef = fb_reg;

endmodule

>>> sv/iirdf_datapath.sv
// Single-pass filter arithmetic: products, saturating sum, rounding and clipping.
module iirdf_datapath #(
    parameter int SAMPLE_BITS = 16,
    parameter int TAPS        = 3
) (
    input  logic signed [SAMPLE_BITS-1:0]                        x,
    input  logic                                                 first,
    input  logic signed [SAMPLE_BITS-1:0]                        x_hist [TAPS],
    input  logic signed [SAMPLE_BITS+iirdf_pkg::HIST_EXTRA-1:0]  y_hist [TAPS],
    input  logic signed [iirdf_pkg::COEF_W-1:0]                  ff_coef [TAPS+1],
    input  logic signed [iirdf_pkg::COEF_W-1:0]                  fb_coef [TAPS],
    output logic signed [SAMPLE_BITS-1:0]                        y,
    output logic                                                 y_sat,
    output logic signed [SAMPLE_BITS+iirdf_pkg::HIST_EXTRA-1:0]  y_full
);
    import iirdf_pkg::*;

    localparam int HIST_BITS = SAMPLE_BITS + HIST_EXTRA;
    localparam int OUT_SHIFT = HIST_SHIFT + HIST_EXTRA;

    localparam logic signed [ACC_W:0] HALF_OUT  = 65'sd1 <<< (OUT_SHIFT - 1);
    localparam logic signed [ACC_W:0] HALF_HIST = 65'sd1 <<< (HIST_SHIFT - 1);
    localparam logic signed [ACC_W:0] HI_OUT    = (65'sd1 <<< (SAMPLE_BITS - 1)) - 65'sd1;
    localparam logic signed [ACC_W:0] LO_OUT    = -HI_OUT - 65'sd1;
    localparam logic signed [ACC_W:0] HI_HIST   = (65'sd1 <<< (HIST_BITS - 1)) - 65'sd1;
    localparam logic signed [ACC_W:0] LO_HIST   = -HI_HIST - 65'sd1;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat_add = s[ACC_W-1:0];
        end
    endfunction

    logic signed [ACC_W-1:0]     acc;
    logic signed [ACC_W-1:0]     pf;
    logic signed [ACC_W-1:0]     pb;
    logic signed [SAMPLE_BITS-1:0] xk;
    logic signed [HIST_BITS-1:0] yk;
    logic signed [ACC_W:0]       acc_ext;
    logic signed [ACC_W:0]       rnd_out;
    logic signed [ACC_W:0]       rnd_hist;

    always_comb begin
        acc = ACC_W'(ff_coef[0] * x) <<< HIST_EXTRA;
        pf  = '0;
        pb  = '0;
        xk  = '0;
        yk  = '0;
        for (int k = 1; k <= TAPS; k++) begin
            xk  = first ? '0 : x_hist[k-1];
            yk  = first ? '0 : y_hist[k-1];
            pf  = ACC_W'(ff_coef[k] * xk) <<< HIST_EXTRA;
            pb  = ACC_W'(fb_coef[k-1] * yk);
            acc = sat_add(acc, pf);
            acc = sat_add(acc, -pb);
        end

        acc_ext  = {acc[ACC_W-1], acc};
        rnd_out  = (acc_ext + HALF_OUT) >>> OUT_SHIFT;
        rnd_hist = (acc_ext + HALF_HIST) >>> HIST_SHIFT;

        if (rnd_out > HI_OUT) begin
            y     = HI_OUT[SAMPLE_BITS-1:0];
            y_sat = 1'b1;
        end else if (rnd_out < LO_OUT) begin
            y     = LO_OUT[SAMPLE_BITS-1:0];
            y_sat = 1'b1;
        end else begin
            y     = rnd_out[SAMPLE_BITS-1:0];
            y_sat = 1'b0;
        end

        if (rnd_hist > HI_HIST) begin
            y_full = HI_HIST[HIST_BITS-1:0];
        end else if (rnd_hist < LO_HIST) begin
            y_full = LO_HIST[HIST_BITS-1:0];
        end else begin
            y_full = rnd_hist[HIST_BITS-1:0];
        end
    end

endmodule

>>> sv/iir_direct_form_filter.sv
// Top level of the third-order direct-form-I IIR filter.
//
// Usage:
//   Input requests arrive on s_valid/s_ready with s_sample_in (signed Q1.15)
//   and s_first_sample; a set first-sample flag starts the filter from zero
//   history. Results leave on m_valid/m_ready as m_sample_out (rounded,
//   saturated) with m_saturated marking a clip.
//   Coefficients b0..b3 (index 0..3) and a1..a3 (index 4..6), signed Q4.20,
//   are written through cfg_we/cfg_index/cfg_wdata while the filter is idle.
//   A request accepted into the input register is computed combinationally
//   from it and captured in the result register, which drives m_valid.
//   The filter takes one sample per cycle while the receiver does not stall;
//   the feedback recurrence closes through the registered output history.
//   Reset (aresetn low, synchronous) clears coefficients, both histories and
//   both valid flags. When the receiver stalls, the result register holds,
//   the input register fills, and s_ready drops until m_ready returns.
module iir_direct_form_filter #(
    parameter int FILTER_ORDER = iirdf_pkg::FILTER_ORDER_DEF,
    parameter int SAMPLE_BITS  = iirdf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [iirdf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [iirdf_pkg::COEF_W-1:0]         cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [SAMPLE_BITS-1:0]        s_sample_in,
    input  logic                                 s_first_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [SAMPLE_BITS-1:0]        m_sample_out,
    output logic                                 m_saturated
);
    import iirdf_pkg::*;

    localparam int TAPS      = (FILTER_ORDER < MAX_TAPS) ? FILTER_ORDER : MAX_TAPS;
    localparam int HIST_BITS = SAMPLE_BITS + HIST_EXTRA;

    logic signed [COEF_W-1:0]      ff_coef [TAPS+1];
    logic signed [COEF_W-1:0]      fb_coef [TAPS];

    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic                          in_first_reg;
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          out_sat_reg;
    logic signed [SAMPLE_BITS-1:0] x_hist_reg  [TAPS];
    logic signed [HIST_BITS-1:0]   y_hist_reg  [TAPS];
    logic signed [SAMPLE_BITS-1:0] x_hist_next [TAPS];
    logic signed [HIST_BITS-1:0]   y_hist_next [TAPS];

    logic signed [SAMPLE_BITS-1:0] y;
    logic                          y_sat;
    logic signed [HIST_BITS-1:0]   y_full;
    logic                          advance;
    logic                          fire;

    iirdf_coef_regs #(
        .TAPS (TAPS)
    ) u_coef_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ff_coef   (ff_coef),
        .fb_coef   (fb_coef)
    );

    iirdf_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TAPS        (TAPS)
    ) u_datapath (
        .x       (in_sample_reg),
        .first   (in_first_reg),
        .x_hist  (x_hist_reg),
        .y_hist  (y_hist_reg),
        .ff_coef (ff_coef),
        .fb_coef (fb_coef),
        .y       (y),
        .y_sat   (y_sat),
        .y_full  (y_full)
    );

    assign advance = !m_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // history shift; a first-sample request drops the old taps
    always_comb begin
        x_hist_next[0] = in_sample_reg;
        y_hist_next[0] = y_full;
        for (int k = 1; k < TAPS; k++) begin
            x_hist_next[k] = in_first_reg ? '0 : x_hist_reg[k-1];
            y_hist_next[k] = in_first_reg ? '0 : y_hist_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int k = 0; k < TAPS; k++) begin
                x_hist_reg[k] <= '0;
                y_hist_reg[k] <= '0;
            end
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                x_hist_reg <= x_hist_next;
                y_hist_reg <= y_hist_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sample_in;
            in_first_reg  <= s_first_sample;
        end
        if (fire) begin
            out_sample_reg <= y;
            out_sat_reg    <= y_sat;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = out_sample_reg;
    assign m_saturated  = out_sat_reg;

endmodule
